FILE: hw/rtl/ppema_pkg.sv
// ============================================================================
// ppema_pkg
// Shared types and constants for the per-pixel EMA smoother with dropout hold.
// ============================================================================
package ppema_pkg;

    // Frame geometry and sample format
    localparam int FRAME_WIDTH  = 32;
    localparam int FRAME_HEIGHT = 24;
    localparam int PIXELS       = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int IDX_W        = 10;
    localparam int SAMPLE_W     = 16;
    localparam int ALPHA_W      = 17;
    localparam int COUNT_W      = 16;
    localparam int TOTAL_W      = 10;

    // Blend arithmetic: (alpha + sign) * (diff) and rounding constant
    localparam int DIFF_W       = SAMPLE_W + 1;
    localparam int PROD_W       = ALPHA_W + 1 + DIFF_W + 1;
    localparam int FRAC_W       = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(65536);
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(32768);
    localparam logic [COUNT_W-1:0] THRESH_RESET = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);
    localparam logic [IDX_W-1:0] LAST_PIXEL = IDX_W'(PIXELS - 1);

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = ALPHA_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SMOOTH_EN = 2'd0,
        CFG_ALPHA     = 2'd1,
        CFG_THRESHOLD = 2'd2
    } cfg_sel_t;

    typedef struct packed {
        logic                 smoothing_enable;
        logic [ALPHA_W-1:0]   alpha;
        logic [COUNT_W-1:0]   invalid_threshold;
    } cfg_t;

    // Input and result transactions
    typedef struct packed {
        logic [IDX_W-1:0]           pixel_index;
        logic signed [SAMPLE_W-1:0] temperature;
        logic                       sample_valid;
        logic                       frame_last;
    } in_t;

    typedef struct packed {
        logic [IDX_W-1:0]           out_index;
        logic signed [SAMPLE_W-1:0] smoothed;
        logic                       out_valid;
        logic                       any_history;
        logic                       out_last;
    } out_t;

    // Per-pixel state entry (ready flag and invalid count live in one RAM,
    // the stored value in another)
    localparam int STATE_W = 1 + COUNT_W;

    typedef struct packed {
        logic                       ready;
        logic [COUNT_W-1:0]         count;
        logic signed [SAMPLE_W-1:0] value;
    } pix_entry_t;

    // Update control handed from the update logic to the top level
    typedef struct packed {
        logic active;
        logic total_inc;
        logic total_dec;
    } upd_ctl_t;

endpackage

FILE: hw/rtl/ppema_ram.sv
// ============================================================================
// ppema_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module ppema_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 768
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/ppema_cfg_regs.sv
// ============================================================================
// ppema_cfg_regs
// Configuration registers: smoothing enable, alpha and invalid threshold.
// ============================================================================
module ppema_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ppema_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ppema_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ppema_pkg::cfg_t                    cfg
);
    import ppema_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SMOOTH_EN: cfg_next.smoothing_enable  = cfg_data[0];
                CFG_ALPHA:     cfg_next.alpha             = cfg_data[ALPHA_W-1:0];
                CFG_THRESHOLD: cfg_next.invalid_threshold = cfg_data[COUNT_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smoothing_enable  <= 1'b1;
            cfg_reg.alpha             <= ALPHA_RESET;
            cfg_reg.invalid_threshold <= THRESH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/ppema_update.sv
// ============================================================================
// ppema_update
// Per-pixel update: blend, seed, hold or drop, and the pass-through case.
// ============================================================================
module ppema_update (
    input  ppema_pkg::cfg_t                       cfg,
    input  ppema_pkg::in_t                        item,
    input  ppema_pkg::pix_entry_t                 entry,
    output ppema_pkg::pix_entry_t                 entry_new,
    output logic signed [ppema_pkg::SAMPLE_W-1:0] smoothed,
    output logic                                  res_ok,
    output ppema_pkg::upd_ctl_t                   ctl
);
    import ppema_pkg::*;

    logic                       active;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   rounded;
    logic signed [PROD_W-FRAC_W-1:0] step;
    logic signed [PROD_W-FRAC_W-1:0] blend_wide;
    logic [COUNT_W-1:0]         count_inc;
    logic                       hold;

    // Smoothing applies only when enabled, alpha is at most one, pixel in frame
    assign active = cfg.smoothing_enable && (cfg.alpha <= ALPHA_ONE)
                    && (item.pixel_index < IDX_W'(PIXELS));

    // Blend: prev + round(alpha * (cur - prev) / 65536)
    assign diff    = DIFF_W'(item.temperature) - DIFF_W'(entry.value);
    assign prod    = PROD_W'($signed({1'b0, cfg.alpha})) * PROD_W'(diff);
    assign rounded = prod + ROUND_HALF;
    assign step    = rounded[PROD_W-1:FRAC_W];
    assign blend_wide = step + (PROD_W-FRAC_W)'(entry.value);

    // Saturating invalid count and hold decision
    assign count_inc = (entry.count == COUNT_MAX) ? entry.count : entry.count + COUNT_W'(1);
    assign hold      = entry.ready && (count_inc < cfg.invalid_threshold);

    always_comb
    begin
        entry_new     = entry;
        smoothed      = '0;
        res_ok        = 1'b0;
        ctl.active    = active;
        ctl.total_inc = 1'b0;
        ctl.total_dec = 1'b0;
        if (!active)
        begin
            // Pass the sample through
            if (item.sample_valid)
            begin
                smoothed = item.temperature;
                res_ok   = 1'b1;
            end
        end
        else if (!item.sample_valid)
        begin
            // Count the dropout, hold or drop the pixel
            entry_new.count = count_inc;
            entry_new.ready = hold;
            if (hold)
            begin
                smoothed = entry.value;
                res_ok   = 1'b1;
            end
            ctl.total_dec = entry.ready && !hold;
        end
        else
        begin
            // Seed or blend
            entry_new.count = '0;
            entry_new.ready = 1'b1;
            if (!entry.ready)
            begin
                entry_new.value = item.temperature;
                ctl.total_inc   = 1'b1;
            end
            else
            begin
                entry_new.value = blend_wide[SAMPLE_W-1:0];
            end
            smoothed = entry_new.value;
            res_ok   = 1'b1;
        end
    end

endmodule

FILE: hw/rtl/per_pixel_ema_with_dropout_hold_core.sv
// ============================================================================
// per_pixel_ema_with_dropout_hold_core
// Per-pixel temporal smoother with dropout hold for a thermal frame.
// ============================================================================
// The block takes one pixel per clock cycle while in_stall is low and returns
// one result per pixel, registered in the update stage and then the result
// register. Per-pixel state sits in two RAMs (ready flag with invalid count,
// and stored value); each pixel is read at accept, updated in the update
// stage by one multiplier and written back, and a forwarding register covers
// the same pixel arriving on consecutive cycles, so that read-modify-write
// loop sets the one pixel per cycle rate. After reset the block clears the
// ready/count RAM and holds in_stall high meanwhile; configuration writes are
// taken at any time and should be made only while the block is idle.
module per_pixel_ema_with_dropout_hold_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ppema_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ppema_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  ppema_pkg::in_t                    in_data,
    output logic                              res_valid,
    input  logic                              res_stall,
    output ppema_pkg::out_t                   res_data
);
    import ppema_pkg::*;

    cfg_t              cfg;
    logic              accept;
    logic              s1_adv;

    // Clearing sweep
    logic              clear_done_reg;
    logic [IDX_W-1:0]  clear_cnt_reg;

    // Update stage
    logic              s1_valid_reg;
    logic              s1_valid_next;
    in_t               s1_item_reg;

    // Forwarding of the most recent write
    logic              fwd_valid_reg;
    logic [IDX_W-1:0]  fwd_idx_reg;
    pix_entry_t        fwd_entry_reg;

    // Initialised pixel count
    logic [TOTAL_W-1:0] ready_total_reg;
    logic [TOTAL_W-1:0] ready_total_next;

    // Result register
    logic              res_valid_reg;
    out_t              res_data_reg;

    // RAM ports
    logic              rd_en;
    logic [STATE_W-1:0]  st_rd_data;
    logic [SAMPLE_W-1:0] val_rd_data;
    logic              st_we;
    logic [IDX_W-1:0]  st_waddr;
    logic [STATE_W-1:0] st_wdata;
    logic              val_we;

    pix_entry_t        ram_entry;
    pix_entry_t        cur_entry;
    pix_entry_t        entry_new;
    logic signed [SAMPLE_W-1:0] smoothed;
    logic              res_ok;
    upd_ctl_t          ctl;

    ppema_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake
    assign s1_adv   = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign in_stall = !clear_done_reg || (s1_valid_reg && !s1_adv);
    assign accept   = in_valid && !in_stall;
    assign rd_en    = accept && (in_data.pixel_index < IDX_W'(PIXELS));

    assign s1_valid_next = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    // Write port muxing: clearing sweep owns the state RAM until done
    assign st_we    = !clear_done_reg || (s1_adv && ctl.active);
    assign st_waddr = clear_done_reg ? s1_item_reg.pixel_index : clear_cnt_reg;
    assign st_wdata = clear_done_reg ? {entry_new.ready, entry_new.count} : '0;
    assign val_we   = s1_adv && ctl.active;

    ppema_ram #(
        .WIDTH (STATE_W),
        .DEPTH (PIXELS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (st_wdata),
        .rd_en   (rd_en),
        .rd_addr (in_data.pixel_index),
        .rd_data (st_rd_data)
    );

    ppema_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (PIXELS)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (val_we),
        .wr_addr (s1_item_reg.pixel_index),
        .wr_data (entry_new.value),
        .rd_en   (rd_en),
        .rd_addr (in_data.pixel_index),
        .rd_data (val_rd_data)
    );

    // Take the latest write for this pixel over the RAM data
    assign ram_entry.ready = st_rd_data[STATE_W-1];
    assign ram_entry.count = st_rd_data[COUNT_W-1:0];
    assign ram_entry.value = val_rd_data;
    assign cur_entry = (fwd_valid_reg && (fwd_idx_reg == s1_item_reg.pixel_index))
                       ? fwd_entry_reg : ram_entry;

    ppema_update u_update (
        .cfg       (cfg),
        .item      (s1_item_reg),
        .entry     (cur_entry),
        .entry_new (entry_new),
        .smoothed  (smoothed),
        .res_ok    (res_ok),
        .ctl       (ctl)
    );

    // Advance the initialised pixel count
    always_comb
    begin
        ready_total_next = ready_total_reg;
        if (s1_adv)
        begin
            ready_total_next = ready_total_reg + TOTAL_W'(ctl.total_inc)
                               - TOTAL_W'(ctl.total_dec);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_done_reg  <= 1'b0;
            clear_cnt_reg   <= '0;
            s1_valid_reg    <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            ready_total_reg <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            // Sweep the state RAM once after reset
            if (!clear_done_reg)
            begin
                if (clear_cnt_reg == LAST_PIXEL)
                begin
                    clear_done_reg <= 1'b1;
                end
                else
                begin
                    clear_cnt_reg <= clear_cnt_reg + IDX_W'(1);
                end
            end
            s1_valid_reg    <= s1_valid_next;
            ready_total_reg <= ready_total_next;
            if (val_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (s1_adv)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_data;
        end
        if (val_we)
        begin
            fwd_idx_reg   <= s1_item_reg.pixel_index;
            fwd_entry_reg <= entry_new;
        end
        if (s1_adv)
        begin
            res_data_reg.out_index   <= s1_item_reg.pixel_index;
            res_data_reg.smoothed    <= smoothed;
            res_data_reg.out_valid   <= res_ok;
            res_data_reg.any_history <= (ready_total_next != '0);
            res_data_reg.out_last    <= s1_item_reg.frame_last;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // No transaction enters before the clearing sweep is done
    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        !clear_done_reg |-> (in_stall && !s1_valid_reg))
        else $error("transaction accepted during clearing sweep");

    // Clearing completes once and stays complete
    a_clear_sticky: assert property (
        @(posedge clk) disable iff (!rst_n)
        clear_done_reg |=> clear_done_reg)
        else $error("clearing sweep restarted");

    // Initialised pixel count never exceeds the frame size
    a_total_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        ready_total_reg <= TOTAL_W'(PIXELS))
        else $error("initialised pixel count out of range");

    // Count never goes up and down in the same step
    a_total_step: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_adv |-> !(ctl.total_inc && ctl.total_dec))
        else $error("pixel count both raised and lowered");

    // A held stage keeps its transaction; in_stall blocks new ones meanwhile
    a_stage_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg)
        else $error("update stage lost a transaction");

endmodule

FILE: dv/pixel_ema_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// pixel_ema_checker
// Watches both channels of the per-pixel EMA smoother, predicts each result
// and compares it field by field.
// ============================================================================
// Keeps its own copy of the per-pixel state and of the settings. Every
// accepted pixel is run through the predictor and the expected result is
// queued; every accepted result is checked against the oldest entry.
module pixel_ema_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ppema_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ppema_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  ppema_pkg::in_t                    in_data,
    input  logic                              res_valid,
    input  logic                              res_stall,
    input  ppema_pkg::out_t                   res_data,
    output int                                failures,
    output int                                pending
);
    import ppema_pkg::*;

    // Settings as last written
    logic               smooth_on;
    logic [ALPHA_W-1:0] blend_alpha;
    logic [COUNT_W-1:0] drop_threshold;

    // Per-pixel history; stored values are kept in offset binary
    logic [SAMPLE_W-1:0] stored_value [PIXELS];
    logic [COUNT_W-1:0]  bad_run      [PIXELS];
    logic                pixel_live   [PIXELS];
    int                  live_total;

    out_t expected_pixels [$];
    int   error_total;

    // Count an error, print only the first few
    task automatic flag_error(input string what);
        error_total++;
        if (error_total <= 10)
            $display("ERROR: %s", what);
    endtask

    task automatic check_field(input string field, input int unsigned pixel,
                               input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got)
            flag_error($sformatf("%s of pixel %0d: expected %0d, got %0d",
                                 field, pixel, want, got));
    endtask

    // Advance the pixel history by one sample and return the result it gives
    function automatic out_t predict_pixel(input in_t px);
        out_t               r;
        int unsigned        i;
        logic               bypass;
        logic [SAMPLE_W-1:0] cur;
        longint unsigned    w_new;
        longint unsigned    w_old;
        longint unsigned    blend;
        r = '0;
        i = px.pixel_index;
        r.out_index = px.pixel_index;
        r.out_last  = px.frame_last;
        bypass = !smooth_on || (blend_alpha > ALPHA_ONE) || (i >= PIXELS);
        if (bypass) begin
            // pass the sample through, leave the history alone
            if (px.sample_valid) begin
                r.smoothed  = px.temperature;
                r.out_valid = 1'b1;
            end
        end else if (!px.sample_valid) begin
            // dropout: hold while below the threshold, else drop the pixel
            if (bad_run[i] != COUNT_MAX)
                bad_run[i]++;
            if (pixel_live[i] && bad_run[i] < drop_threshold) begin
                r.smoothed  = stored_value[i] ^ {1'b1, {(SAMPLE_W - 1){1'b0}}};
                r.out_valid = 1'b1;
            end else if (pixel_live[i]) begin
                pixel_live[i] = 1'b0;
                live_total--;
            end
        end else begin
            cur = px.temperature ^ {1'b1, {(SAMPLE_W - 1){1'b0}}};
            bad_run[i] = '0;
            if (!pixel_live[i]) begin
                // seed the pixel with its first sample
                stored_value[i] = cur;
                pixel_live[i]   = 1'b1;
                live_total++;
            end else begin
                // blend with weight alpha, round half up
                w_new = blend_alpha;
                w_old = longint'(ALPHA_ONE) - w_new;
                blend = w_new * cur + w_old * stored_value[i] + (1 << (FRAC_W - 1));
                stored_value[i] = blend[FRAC_W +: SAMPLE_W];
            end
            r.smoothed  = stored_value[i] ^ {1'b1, {(SAMPLE_W - 1){1'b0}}};
            r.out_valid = 1'b1;
        end
        r.any_history = (live_total != 0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            smooth_on      = 1'b1;
            blend_alpha    = ALPHA_RESET;
            drop_threshold = THRESH_RESET;
            for (int k = 0; k < PIXELS; k++)
            begin
                stored_value[k] = '0;
                bad_run[k]      = '0;
                pixel_live[k]   = 1'b0;
            end
            live_total  = 0;
            error_total = 0;
            expected_pixels.delete();
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            // track register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SMOOTH_EN: smooth_on      = cfg_data[0];
                    CFG_ALPHA:     blend_alpha    = cfg_data[ALPHA_W-1:0];
                    CFG_THRESHOLD: drop_threshold = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end

            // predict each accepted pixel
            if (in_valid && !in_stall)
                expected_pixels.push_back(predict_pixel(in_data));

            // compare each accepted result with the oldest prediction
            if (res_valid && !res_stall)
            begin
                if (expected_pixels.size() == 0)
                    flag_error($sformatf("result for pixel %0d with none expected",
                                         res_data.out_index));
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("out_index", want.out_index,
                                want.out_index, res_data.out_index);
                    check_field("smoothed", want.out_index,
                                want.smoothed, res_data.smoothed);
                    check_field("out_valid", want.out_index,
                                want.out_valid, res_data.out_valid);
                    check_field("any_history", want.out_index,
                                want.any_history, res_data.any_history);
                    check_field("out_last", want.out_index,
                                want.out_last, res_data.out_last);
                end
            end

            failures <= error_total;
            pending  <= expected_pixels.size();
        end
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Stimulus and verdict for the per-pixel EMA smoother with dropout hold.
// ============================================================================
// A directed pass covers field extremes, seeding, blending, dropout hold and
// drop, the bypass settings and a long hold at the top threshold; random
// phases then run under a range of settings with bursty input and a stalling
// receiver, including one long hold-off that backs the block up.
module testbench;
    import ppema_pkg::*;

    localparam int HOT_COUNT      = 8;
    localparam int PHASE_PIXELS   = 95;
    localparam int LONG_DROPOUT   = 20;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    in_t                    in_data;
    logic                   res_valid;
    logic                   res_stall;
    out_t                   res_data;

    int   failures;
    int   pending;
    int   idle_cycles;
    logic hold_off_req;

    in_t              pixel_queue [$];
    logic [IDX_W-1:0] hot_pixels  [HOT_COUNT];
    int               dropout_left[HOT_COUNT];

    per_pixel_ema_with_dropout_hold_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    pixel_ema_checker ema_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .failures  (failures),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Write all three registers on consecutive cycles
    task automatic configure(input logic en, input logic [ALPHA_W-1:0] weight,
                             input logic [COUNT_W-1:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SMOOTH_EN;
        cfg_data  <= CFG_DATA_W'(en);
        @(posedge clk);
        cfg_index <= CFG_ALPHA;
        cfg_data  <= weight;
        @(posedge clk);
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= CFG_DATA_W'(limit);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic queue_pixel(input int idx, input int temp, input logic ok,
                               input logic last);
        in_t px;
        px.pixel_index  = IDX_W'(idx);
        px.temperature  = SAMPLE_W'(temp);
        px.sample_valid = ok;
        px.frame_last   = last;
        pixel_queue.push_back(px);
    endtask

    // Offer one transaction and hold it until accepted
    task automatic send_pixel(input in_t px);
        in_valid <= 1'b1;
        in_data  <= px;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Send the queued pixels in bursts separated by random gaps
    task automatic play_queue();
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 32);
        while (pixel_queue.size() != 0)
        begin
            send_pixel(pixel_queue.pop_front());
            burst_left--;
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0 && pixel_queue.size() != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 32);
            end
        end
        in_valid <= 1'b0;
    endtask

    // Wait until every predicted result has come back, then let the pipe settle
    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly a few busy pixels with dropout runs, some stray and off-frame ones
    function automatic in_t random_pixel();
        in_t px;
        int  pick;
        int  slot;
        px   = '0;
        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, HOT_COUNT - 1);
        if ($urandom_range(0, 9) == 0)
            px.temperature = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        else
            px.temperature = SAMPLE_W'($urandom());
        px.frame_last = ($urandom_range(0, 15) == 0);
        if (pick < 75)
        begin
            px.pixel_index = hot_pixels[slot];
            if (dropout_left[slot] > 0)
            begin
                dropout_left[slot]--;
                px.sample_valid = 1'b0;
            end
            else
            begin
                px.sample_valid = 1'b1;
                if ($urandom_range(0, 7) == 0)
                    dropout_left[slot] = $urandom_range(1, 6);
            end
        end
        else if (pick < 92)
        begin
            px.pixel_index  = IDX_W'($urandom_range(0, PIXELS - 1));
            px.sample_valid = ($urandom_range(0, 3) != 0);
        end
        else
        begin
            px.pixel_index  = IDX_W'($urandom_range(PIXELS, 2 ** IDX_W - 1));
            px.sample_valid = 1'($urandom_range(0, 1));
        end
        return px;
    endfunction

    // Receiver: stall on its own changing pattern, plus one long hold-off
    initial
    begin : receiver
        int  mode;
        int  span;
        logic hold_done;
        mode      = 0;
        span      = 0;
        hold_done = 1'b0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_done)
            begin
                hold_done = 1'b1;
                res_stall <= 1'b1;
                repeat (HOLD_OFF_LEN) @(posedge clk);
            end
            if (span == 0)
            begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(32, 256);
            end
            span--;
            case (mode)
                0:       res_stall <= 1'b0;
                1:       res_stall <= ($urandom_range(0, 3) == 0);
                default: res_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (res_valid && !res_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        hold_off_req <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_SMOOTH_EN;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        in_data      <= '0;
        rst_n        <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        hot_pixels[0] = '0;
        hot_pixels[1] = LAST_PIXEL;
        for (int k = 2; k < HOT_COUNT; k++)
            hot_pixels[k] = IDX_W'($urandom_range(0, PIXELS - 1));
        for (int k = 0; k < HOT_COUNT; k++)
            dropout_left[k] = 0;

        // Reset settings: seed, blend, hold, drop, bypass of off-frame pixels
        queue_pixel(0, 32767, 1'b1, 1'b0);
        queue_pixel(0, -32768, 1'b1, 1'b0);
        queue_pixel(PIXELS - 1, -32768, 1'b1, 1'b1);
        queue_pixel(PIXELS - 1, 32767, 1'b1, 1'b0);
        queue_pixel(PIXELS, 1234, 1'b1, 1'b0);
        queue_pixel(1023, -1, 1'b0, 1'b1);
        repeat (4) queue_pixel(0, 77, 1'b0, 1'b0);
        repeat (4) queue_pixel(PIXELS - 1, -77, 1'b0, 1'b0);
        queue_pixel(5, 0, 1'b1, 1'b1);
        queue_pixel(5, 100, 1'b1, 1'b0);
        queue_pixel(5, 101, 1'b1, 1'b0);
        queue_pixel(5, 0, 1'b0, 1'b0);
        queue_pixel(5, -3, 1'b1, 1'b0);
        queue_pixel(5, 0, 1'b0, 1'b0);
        queue_pixel(5, 0, 1'b0, 1'b1);
        play_queue();
        drain();

        // Zero threshold: the first dropout drops the pixel
        configure(1'b1, ALPHA_RESET, '0);
        queue_pixel(9, 500, 1'b1, 1'b0);
        queue_pixel(9, 0, 1'b0, 1'b0);
        play_queue();
        drain();

        // Smoothing off and alpha above one both pass samples through
        configure(1'b0, ALPHA_RESET, THRESH_RESET);
        queue_pixel(9, -700, 1'b1, 1'b0);
        queue_pixel(9, 0, 1'b0, 1'b1);
        play_queue();
        drain();
        configure(1'b1, ALPHA_W'(65537), THRESH_RESET);
        queue_pixel(9, 42, 1'b1, 1'b0);
        queue_pixel(9, 0, 1'b0, 1'b0);
        play_queue();
        drain();

        // Hold through a long dropout run at the top threshold
        configure(1'b1, ALPHA_ONE, COUNT_MAX);
        queue_pixel(300, -1234, 1'b1, 1'b0);
        repeat (LONG_DROPOUT) queue_pixel(300, 0, 1'b0, 1'b0);
        queue_pixel(300, 4321, 1'b1, 1'b1);
        play_queue();
        drain();

        // Random phases under a spread of settings
        for (int phase = 0; phase < 9; phase++)
        begin
            case (phase)
                0: configure(1'b1, ALPHA_RESET, THRESH_RESET);
                1: configure(1'b1, '0, COUNT_W'(2));
                2: configure(1'b1, ALPHA_ONE, COUNT_W'(5));
                3: configure(1'b1, ALPHA_W'($urandom_range(1, 65535)),
                             COUNT_W'($urandom_range(0, 8)));
                4: configure(1'b0, ALPHA_W'($urandom_range(0, 65536)), THRESH_RESET);
                5: configure(1'b1, ALPHA_W'($urandom_range(65537, 131071)), THRESH_RESET);
                6: configure(1'b1, ALPHA_W'(1), COUNT_MAX);
                7: configure(1'b1, ALPHA_W'($urandom_range(0, 65536)), COUNT_W'(1));
                default: configure(1'b1, {ALPHA_W{1'b1}}, '0);
            endcase
            if (phase == 0)
                hold_off_req <= 1'b1;
            repeat (PHASE_PIXELS) pixel_queue.push_back(random_pixel());
            play_queue();
            drain();
        end

        if (failures == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
